// ----- src/gbtok_pkg.sv -----
// Shared types and constants for the GB2312 text tokenizer.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package gbtok_pkg;

  localparam int POS_WIDTH = 14;

  localparam logic [1:0] KIND_WORD   = 2'd0;
  localparam logic [1:0] KIND_NUMBER = 2'd1;
  localparam logic [1:0] KIND_CJK    = 2'd2;

  localparam logic [2:0] REG_SCAN_LIMIT     = 3'd0;
  localparam logic [2:0] REG_WORD_MAX_LEN   = 3'd1;
  localparam logic [2:0] REG_NUMBER_MAX_LEN = 3'd2;
  localparam logic [2:0] REG_CJK_MAX_LEN    = 3'd3;
  localparam logic [2:0] REG_NEWLINE_LIMIT  = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_word_t;

  typedef struct packed {
    logic                 event_res;
    logic [1:0]           kind;
    logic [7:0]           token_byte;
    logic [POS_WIDTH-1:0] start_pos;
    logic [6:0]           token_len;
  } out_word_t;

  // All result words caused by one input byte, in order.
  typedef struct packed {
    logic [1:0]      count;
    out_word_t [2:0] item;
  } bundle_t;

  function automatic out_word_t make_word(input logic ev, input logic [1:0] kind,
                                          input logic [7:0] b,
                                          input logic [POS_WIDTH-1:0] pos,
                                          input logic [6:0] len);
    out_word_t w;
    w.event_res  = ev;
    w.kind       = kind;
    w.token_byte = b;
    w.start_pos  = pos;
    w.token_len  = len;
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- src/gbtok_front.sv -----
// Front end of the tokenizer: configuration registers and the scan state machine.
// Classifies each byte and produces the bundle of result words it causes; uses gbtok_pkg.
`default_nettype none

module gbtok_front
  import gbtok_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  output logic           item_ready,
  input  wire in_word_t  item,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [13:0] cfg_data,
  input  wire logic      q_ready,
  output logic           push,
  output bundle_t        bundle
);

  typedef enum logic [2:0] {
    M_IDLE, M_WORD, M_NUMBER, M_CJK, M_SKIP1, M_SKIPESC
  } mode_t;

  localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_HIGH  = 8'h80;
  localparam logic [6:0] CJK_CAP  = 7'd100;

  function automatic logic is_letter(input logic [7:0] b);
    return (b inside {[8'h41:8'h5A]}) || (b inside {[8'h61:8'h7A]});
  endfunction

  function automatic logic is_upper(input logic [7:0] b);
    return b inside {[8'h41:8'h5A]};
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_lead(input logic [7:0] b);
    return b inside {[8'hB0:8'hF7]};
  endfunction

  function automatic logic is_trail(input logic [7:0] b);
    return b inside {[8'hA1:8'hFE]};
  endfunction

  logic [13:0] scan_limit;
  logic [3:0]  word_max_len;
  logic [3:0]  number_max_len;
  logic [6:0]  cjk_max_len;
  logic [1:0]  newline_limit;

  mode_t                mode, mode_next;
  logic [POS_WIDTH-1:0] cons, cons_next;
  logic [6:0]           clen, clen_next;
  logic [POS_WIDTH-1:0] tstart, tstart_next;
  logic [7:0]           held, held_next;
  logic                 await_trail, await_next;
  logic [1:0]           nlc, nlc_next;
  logic                 stopped, stopped_next;

  logic accept;
  assign accept     = item_valid && item_ready;
  assign item_ready = q_ready;
  assign cfg_ready  = 1'b1;
  assign push       = accept && (bundle.count != 2'd0);

  always_comb begin
    logic [7:0] b;
    logic       eof;
    logic       do_end, do_term, do_start, ok;
    logic [3:0] cap;
    logic [6:0] cmax;
    logic [1:0] n;
    bundle_t    bnd;

    b   = item.data_byte;
    eof = item.end_of_file;
    cmax = (cjk_max_len > CJK_CAP) ? CJK_CAP : cjk_max_len;
    mode_next    = mode;
    cons_next    = cons;
    clen_next    = clen;
    tstart_next  = tstart;
    held_next    = held;
    await_next   = await_trail;
    nlc_next     = nlc;
    stopped_next = stopped;
    do_end   = 1'b0;
    do_term  = 1'b0;
    do_start = 1'b0;
    ok  = 1'b0;
    cap = 4'd0;
    n   = 2'd0;
    bnd = '0;

    if (!stopped) begin
      if (cons != POS_MAX) begin
        cons_next = cons + 1'b1;
      end
      case (mode)
        M_WORD, M_NUMBER: begin
          ok  = (mode == M_WORD) ? (is_letter(b) || is_digit(b)) : is_digit(b);
          cap = (mode == M_WORD) ? word_max_len : number_max_len;
          if (b == CH_NUL) begin
            do_end = 1'b1;
            stopped_next = 1'b1;
          end else if (ok && (clen < {3'd0, cap})) begin
            bnd.item[n] = make_word(1'b0, (mode == M_WORD) ? KIND_WORD : KIND_NUMBER,
                                    is_upper(b) ? (b | 8'h20) : b, tstart_next, 7'd0);
            n = n + 2'd1;
            clen_next = clen + 7'd1;
          end else begin
            do_term = 1'b1;
          end
        end
        M_CJK: begin
          if (b == CH_NUL) begin
            do_end = 1'b1;
            stopped_next = 1'b1;
          end else if (await_trail) begin
            if (is_trail(b)) begin
              bnd.item[0] = make_word(1'b0, KIND_CJK, held, tstart_next, 7'd0);
              bnd.item[1] = make_word(1'b0, KIND_CJK, b, tstart_next, 7'd0);
              n = 2'd2;
              clen_next  = clen + 7'd2;
              await_next = 1'b0;
              held_next  = 8'd0;
            end else begin
              do_term = 1'b1;
            end
          end else if (is_lead(b)) begin
            if (clen >= cmax) begin
              do_term = 1'b1;
            end else begin
              held_next  = b;
              await_next = 1'b1;
              nlc_next   = 2'd0;
            end
          end else if (b == CH_SPACE) begin
            nlc_next = nlc;
          end else if ((b == CH_LF) || (b == CH_CR)) begin
            if (({1'b0, nlc} + 3'd1) >= {1'b0, newline_limit}) begin
              do_term = 1'b1;
            end else begin
              nlc_next = nlc + 2'd1;
            end
          end else begin
            do_term = 1'b1;
          end
        end
        M_SKIP1: begin
          mode_next = M_IDLE;
          if ({{(32 - POS_WIDTH){1'b0}}, cons_next} > {18'd0, scan_limit}) begin
            stopped_next = 1'b1;
          end
        end
        M_SKIPESC: begin
          if (is_letter(b)) begin
            mode_next = M_IDLE;
            if ({{(32 - POS_WIDTH){1'b0}}, cons_next} > {18'd0, scan_limit}) begin
              stopped_next = 1'b1;
            end
          end
        end
        default: begin
          if (b == CH_NUL) begin
            mode_next = M_IDLE;
            stopped_next = 1'b1;
          end else begin
            do_start = 1'b1;
          end
        end
      endcase

      if (do_end || do_term) begin
        if ((mode == M_WORD) || (mode == M_NUMBER) ||
            ((mode == M_CJK) && (clen_next != 7'd0))) begin
          bnd.item[n] = make_word(1'b1, (mode == M_WORD) ? KIND_WORD :
                                  (mode == M_NUMBER) ? KIND_NUMBER : KIND_CJK,
                                  8'd0, tstart_next, clen_next);
          n = n + 2'd1;
        end
        mode_next  = M_IDLE;
        clen_next  = 7'd0;
        held_next  = 8'd0;
        await_next = 1'b0;
        nlc_next   = 2'd0;
      end

      if (do_term) begin
        if ({{(32 - POS_WIDTH){1'b0}}, cons_next} > {18'd0, scan_limit}) begin
          stopped_next = 1'b1;
        end
        do_start = !stopped_next && !eof;
      end

      if (do_start) begin
        tstart_next = cons_next - 1'b1;
        if (is_letter(b)) begin
          mode_next = M_WORD;
          clen_next = 7'd1;
          bnd.item[n] = make_word(1'b0, KIND_WORD, is_upper(b) ? (b | 8'h20) : b,
                                  tstart_next, 7'd0);
          n = n + 2'd1;
        end else if (is_digit(b)) begin
          mode_next = M_NUMBER;
          clen_next = 7'd1;
          bnd.item[n] = make_word(1'b0, KIND_NUMBER, b, tstart_next, 7'd0);
          n = n + 2'd1;
        end else if (is_lead(b)) begin
          mode_next  = M_CJK;
          clen_next  = 7'd0;
          held_next  = b;
          await_next = 1'b1;
          nlc_next   = 2'd0;
        end else if (b >= CH_HIGH) begin
          mode_next = M_SKIP1;
        end else if (b == CH_ESC) begin
          mode_next = M_SKIPESC;
        end else begin
          mode_next = M_IDLE;
          if ({{(32 - POS_WIDTH){1'b0}}, cons_next} > {18'd0, scan_limit}) begin
            stopped_next = 1'b1;
          end
        end
      end
    end

    if (eof) begin
      if ((mode_next == M_WORD) || (mode_next == M_NUMBER) ||
          ((mode_next == M_CJK) && (clen_next != 7'd0))) begin
        bnd.item[n] = make_word(1'b1, (mode_next == M_WORD) ? KIND_WORD :
                                (mode_next == M_NUMBER) ? KIND_NUMBER : KIND_CJK,
                                8'd0, tstart_next, clen_next);
        n = n + 2'd1;
      end
      mode_next    = M_IDLE;
      clen_next    = 7'd0;
      held_next    = 8'd0;
      await_next   = 1'b0;
      nlc_next     = 2'd0;
      cons_next    = '0;
      tstart_next  = '0;
      stopped_next = 1'b0;
    end

    bnd.count = n;
    bundle = bnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_IDLE;
      cons        <= '0;
      clen        <= 7'd0;
      tstart      <= '0;
      held        <= 8'd0;
      await_trail <= 1'b0;
      nlc         <= 2'd0;
      stopped     <= 1'b0;
    end else if (accept) begin
      mode        <= mode_next;
      cons        <= cons_next;
      clen        <= clen_next;
      tstart      <= tstart_next;
      held        <= held_next;
      await_trail <= await_next;
      nlc         <= nlc_next;
      stopped     <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_limit     <= 14'd10240;
      word_max_len   <= 4'd12;
      number_max_len <= 4'd5;
      cjk_max_len    <= 7'd100;
      newline_limit  <= 2'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCAN_LIMIT:     scan_limit     <= cfg_data;
        REG_WORD_MAX_LEN:   word_max_len   <= cfg_data[3:0];
        REG_NUMBER_MAX_LEN: number_max_len <= cfg_data[3:0];
        REG_CJK_MAX_LEN:    cjk_max_len    <= cfg_data[6:0];
        REG_NEWLINE_LIMIT:  newline_limit  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/gbtok_queue.sv -----
// Four-entry queue of result bundles between the front and back ends.
// Uses the bundle type from gbtok_pkg.
`default_nettype none

module gbtok_queue
  import gbtok_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire bundle_t wr_bundle,
  output logic         q_ready,
  input  wire logic    pop,
  output logic         nonempty,
  output bundle_t      head
);

  bundle_t    entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;

  assign q_ready  = (fill != 3'd4);
  assign nonempty = (fill != 3'd0);
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      fill   <= 3'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 3'd1;
        2'b01:   fill <= fill - 3'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/gbtok_back.sv -----
// Back end of the tokenizer: unpacks queued bundles into single result words.
// Drives the output register of the block; uses gbtok_pkg.
`default_nettype none

module gbtok_back
  import gbtok_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    nonempty,
  input  wire bundle_t head,
  output logic         pop,
  output logic         token_valid,
  input  wire logic    token_ready,
  output out_word_t    token
);

  logic [1:0] idx;
  logic       load;
  logic       last;

  assign load = nonempty && (!token_valid || token_ready);
  assign last = (idx == (head.count - 2'd1));
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
      idx         <= 2'd0;
    end else begin
      if (load) begin
        token_valid <= 1'b1;
        idx         <= last ? 2'd0 : idx + 2'd1;
      end else if (token_ready) begin
        token_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      token <= head.item[idx];
    end
  end

endmodule

`default_nettype wire

// ----- src/gb2312_text_tokenizer.sv -----
// Top level of the GB2312 text tokenizer.
// Connects gbtok_front, gbtok_queue and gbtok_back; uses gbtok_pkg.
//
// The block takes one text byte per word on the item channel and reports every accepted
// token byte and every token end as result words on the token channel. A byte is
// accepted in the cycle it arrives whenever the four-entry result queue has room, so
// input runs at one byte per cycle. One byte can cause up to three result words, and
// the output register drains one word per cycle while token_ready is high, so a
// sustained stream of bytes that each cause several words is limited to one result
// word per cycle by that register. Configuration writes are taken at once and should
// only be made while the block is idle.
`default_nettype none

module gb2312_text_tokenizer
  import gbtok_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire in_word_t    item,
  output logic             token_valid,
  input  wire logic        token_ready,
  output out_word_t        token,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [13:0] cfg_data
);

  logic    q_ready;
  logic    push;
  bundle_t bundle;
  logic    pop;
  logic    nonempty;
  bundle_t head;

  gbtok_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_ready    (q_ready),
    .push       (push),
    .bundle     (bundle)
  );

  gbtok_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_bundle (bundle),
    .q_ready   (q_ready),
    .pop       (pop),
    .nonempty  (nonempty),
    .head      (head)
  );

  gbtok_back u_back (
    .clk         (clk),
    .rst         (rst),
    .nonempty    (nonempty),
    .head        (head),
    .pop         (pop),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token       (token)
  );

endmodule

`default_nettype wire

// ----- src/gbtok_checker.sv -----
// Port-level checker for the GB2312 text tokenizer, bound to its top level.
// Watches the token channel only; uses gbtok_pkg.
`default_nettype none

module gbtok_port_checks
  import gbtok_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      token_valid,
  input wire logic      token_ready,
  input wire out_word_t token
);

  a_end_byte_zero: assert property (@(posedge clk) disable iff (rst)
    token_valid && token.event_res |-> token.token_byte == 8'd0)
    else $error("end word carries a nonzero byte");

  a_end_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    token_valid && token.event_res |-> token.token_len != 7'd0)
    else $error("end word reports an empty token");

  a_byte_len_zero: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token.event_res |-> token.token_len == 7'd0)
    else $error("byte word carries a length");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> (token.kind == KIND_WORD) || (token.kind == KIND_NUMBER) ||
                    (token.kind == KIND_CJK))
    else $error("unknown token kind");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_ready |=> token_valid && $stable(token))
    else $error("stalled result word changed");

endmodule

bind gb2312_text_tokenizer gbtok_port_checks u_checker (
  .clk         (clk),
  .rst         (rst),
  .token_valid (token_valid),
  .token_ready (token_ready),
  .token       (token)
);

`default_nettype wire
